// ===== rtl/core/lqwl_pkg.sv =====
package lqwl_pkg;

    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_COUNT    = 3'd2;
    localparam logic [2:0] CMD_LIST_OLD = 3'd3;
    localparam logic [2:0] CMD_LIST_NEW = 3'd4;

    localparam logic [1:0] KIND_REMOVED = 2'd0;
    localparam logic [1:0] KIND_COUNT   = 2'd1;
    localparam logic [1:0] KIND_LISTED  = 2'd2;

    localparam logic [6:0] CAP_RESET   = 7'd64;
    localparam logic [6:0] MAX_RESULTS = 7'd64;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [30:0] student_id;
        logic [63:0] name_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        found;
        logic [30:0] rec_id;
        logic [63:0] rec_tag;
        logic [6:0]  occupancy;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [30:0] id;
        logic [63:0] tag;
    } rec_t;

    typedef enum logic [1:0] {
        OUT_REMOVED,
        OUT_MISS,
        OUT_COUNT,
        OUT_LISTED
    } out_sel_t;

    typedef struct packed {
        logic     wr_en;
        logic     rd_head;
        logic     list_start;
        logic     list_old;
        logic     list_step;
        logic     pop;
        logic     load_out;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic can_insert;
        logic empty;
        logic last_item;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/lqwl_ctrl.sv =====
module lqwl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  lqwl_pkg::dp_stat_t stat,
    output lqwl_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_MISS,
        ST_COUNT,
        ST_LIST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_sel    = lqwl_pkg::OUT_MISS;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        lqwl_pkg::CMD_INSERT: begin
                            cmd.wr_en = stat.can_insert;
                        end
                        lqwl_pkg::CMD_REMOVE: begin
                            if (stat.empty) begin
                                state_next = ST_MISS;
                            end else begin
                                cmd.rd_head = 1'b1;
                                state_next  = ST_REMOVE;
                            end
                        end
                        lqwl_pkg::CMD_COUNT: begin
                            state_next = ST_COUNT;
                        end
                        default: begin
                            if (!stat.empty) begin
                                cmd.list_start = 1'b1;
                                cmd.list_old   = (s_cmd == lqwl_pkg::CMD_LIST_OLD);
                                state_next     = ST_LIST;
                            end
                        end
                    endcase
                end
            end
            ST_REMOVE: begin
                cmd.out_sel = lqwl_pkg::OUT_REMOVED;
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.pop      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MISS: begin
                cmd.out_sel = lqwl_pkg::OUT_MISS;
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_COUNT: begin
                cmd.out_sel = lqwl_pkg::OUT_COUNT;
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_LIST: begin
                cmd.out_sel = lqwl_pkg::OUT_LISTED;
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    if (stat.last_item) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.list_step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/lqwl_dp.sv =====
module lqwl_dp #(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lqwl_pkg::in_item_t  s_data,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lqwl_pkg::out_item_t m_data,
    input  lqwl_pkg::dp_cmd_t   cmd,
    output lqwl_pkg::dp_stat_t  stat
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (PW > 7) ? PW : 7;

    lqwl_pkg::rec_t mem [DEPTH];

    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [PW-1:0]       cursor_reg, cursor_next;
    logic [6:0]          remain_reg, remain_next;
    logic                dir_old_reg, dir_old_next;
    logic [6:0]          capacity_reg;
    lqwl_pkg::rec_t      rd_reg;
    logic                m_valid_reg;
    lqwl_pkg::out_item_t m_data_reg, m_data_next;

    logic [PW-1:0] count;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] first_pos;
    logic [PW-1:0] step_pos;
    logic [PW-1:0] rd_pos;
    logic          rd_en;

    assign count     = tail_reg - head_reg;
    assign head_inc  = head_reg + PW'(1);
    assign first_pos = cmd.list_old ? head_reg : tail_reg - PW'(1);
    assign step_pos  = dir_old_reg ? cursor_reg + PW'(1) : cursor_reg - PW'(1);
    assign rd_en     = cmd.rd_head || cmd.list_start || cmd.list_step;

    always_comb begin
        priority if (cmd.list_start) begin
            rd_pos = first_pos;
        end else if (cmd.list_step) begin
            rd_pos = step_pos;
        end else begin
            rd_pos = head_reg;
        end
    end

    assign stat.can_insert = (CW'(tail_reg) < CW'(capacity_reg)) && (tail_reg < PW'(DEPTH));
    assign stat.empty      = (count == '0);
    assign stat.last_item  = (remain_reg == 7'd1);
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        cursor_next  = cursor_reg;
        remain_next  = remain_reg;
        dir_old_next = dir_old_reg;
        if (cmd.wr_en) begin
            tail_next = tail_reg + PW'(1);
        end
        if (cmd.pop) begin
            if (head_inc == tail_reg) begin
                head_next = '0;
                tail_next = '0;
            end else begin
                head_next = head_inc;
            end
        end
        if (cmd.list_start) begin
            dir_old_next = cmd.list_old;
            cursor_next  = first_pos;
            if (CW'(count) > CW'(lqwl_pkg::MAX_RESULTS)) begin
                remain_next = lqwl_pkg::MAX_RESULTS;
            end else begin
                remain_next = 7'(count);
            end
        end else if (cmd.list_step) begin
            cursor_next = step_pos;
            remain_next = remain_reg - 7'd1;
        end
    end

    always_comb begin
        m_data_next = '0;
        unique case (cmd.out_sel)
            lqwl_pkg::OUT_REMOVED: begin
                m_data_next.kind    = lqwl_pkg::KIND_REMOVED;
                m_data_next.found   = 1'b1;
                m_data_next.rec_id  = rd_reg.id;
                m_data_next.rec_tag = rd_reg.tag;
                m_data_next.last    = 1'b1;
            end
            lqwl_pkg::OUT_MISS: begin
                m_data_next.kind = lqwl_pkg::KIND_REMOVED;
                m_data_next.last = 1'b1;
            end
            lqwl_pkg::OUT_COUNT: begin
                m_data_next.kind      = lqwl_pkg::KIND_COUNT;
                m_data_next.occupancy = 7'(count);
                m_data_next.last      = 1'b1;
            end
            lqwl_pkg::OUT_LISTED: begin
                m_data_next.kind    = lqwl_pkg::KIND_LISTED;
                m_data_next.rec_id  = rd_reg.id;
                m_data_next.rec_tag = rd_reg.tag;
                m_data_next.last    = stat.last_item;
            end
            default: begin
                m_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[tail_reg[AW-1:0]] <= '{id: s_data.student_id, tag: s_data.name_tag};
        end
        if (rd_en) begin
            rd_reg <= mem[rd_pos[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            cursor_reg   <= '0;
            remain_reg   <= '0;
            dir_old_reg  <= 1'b0;
            capacity_reg <= lqwl_pkg::CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cursor_reg  <= cursor_next;
            remain_reg  <= remain_next;
            dir_old_reg <= dir_old_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/linear_queue_with_listing_unit.sv =====
// Insert: no transaction out; the next command is accepted in the following cycle.
// Remove and count: the result state registers the result when the output is free (remove
// reads the head at the accepting edge), then returns to idle; a stalled output delays idle.
// List: the list state registers one record per cycle while the output is not stalled, from
// the single memory read port, and holds off the input until the last record is registered.
// Synchronous active-low reset clears pointers, capacity (to 64) and output valid, not storage.
module linear_queue_with_listing_unit #(
    parameter int DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lqwl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lqwl_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data
);

    lqwl_pkg::dp_cmd_t  cmd;
    lqwl_pkg::dp_stat_t stat;

    lqwl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_data.cmd),
        .stat    (stat),
        .cmd     (cmd)
    );

    lqwl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== rtl/core/lqwl_checker.sv =====
module lqwl_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lqwl_pkg::out_item_t m_data
);

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output transaction changed while stalled");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind == lqwl_pkg::KIND_REMOVED) ||
                    (m_data.kind == lqwl_pkg::KIND_COUNT) ||
                    (m_data.kind == lqwl_pkg::KIND_LISTED))
        else $error("illegal result kind");

    a_count_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == lqwl_pkg::KIND_COUNT) |->
            m_data.last && !m_data.found && (m_data.rec_id == '0) && (m_data.rec_tag == '0))
        else $error("malformed count report");

    a_miss_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == lqwl_pkg::KIND_REMOVED) && !m_data.found |->
            m_data.last && (m_data.rec_id == '0) && (m_data.rec_tag == '0))
        else $error("malformed empty remove result");

    a_list_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == lqwl_pkg::KIND_LISTED) && !m_data.last |-> !s_ready)
        else $error("input accepted in the middle of a listing");

endmodule

bind linear_queue_with_listing_unit lqwl_checker u_lqwl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/tb_linear_queue_with_listing_unit.sv =====
`timescale 1ns / 1ps

module tb_linear_queue_with_listing_unit;

    localparam int QDEPTH = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    lqwl_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    lqwl_pkg::out_item_t m_data;
    logic                cfg_wr_en = 1'b0;
    logic [6:0]          cfg_wr_data = '0;

    lqwl_pkg::in_item_t  pending_cmds[$];
    lqwl_pkg::out_item_t expected_results[$];

    logic [30:0] id_mem[QDEPTH];
    logic [63:0] tag_mem[QDEPTH];
    int          head_pos = 0;
    int          tail_pos = 0;
    logic [6:0]  capacity_reg = lqwl_pkg::CAP_RESET;

    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_dropped = 0;
    int longest_list = 0;

    int drv_gap_max = 0;
    int drv_seen = 0;
    int drv_wait = 0;
    bit drv_busy = 1'b0;

    int rx_gap_max = 0;
    int rx_seen = 0;
    int rx_wait = 0;
    int rx_hold_req = 0;
    int rx_hold_done = 0;
    int rx_hold_left = 0;

    lqwl_pkg::out_item_t want;

    linear_queue_with_listing_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void predict_results(input lqwl_pkg::in_item_t it);
        int limit;
        int n;
        int pos;
        lqwl_pkg::out_item_t r;
        limit = (capacity_reg < QDEPTH) ? int'(capacity_reg) : QDEPTH;
        r = '0;
        case (it.cmd)
            lqwl_pkg::CMD_INSERT: begin
                if (tail_pos < limit) begin
                    id_mem[tail_pos] = it.student_id;
                    tag_mem[tail_pos] = it.name_tag;
                    tail_pos = tail_pos + 1;
                end else begin
                    n_dropped = n_dropped + 1;
                end
            end
            lqwl_pkg::CMD_REMOVE: begin
                r.kind = lqwl_pkg::KIND_REMOVED;
                r.last = 1'b1;
                if (head_pos < tail_pos) begin
                    r.found = 1'b1;
                    r.rec_id = id_mem[head_pos];
                    r.rec_tag = tag_mem[head_pos];
                    head_pos = head_pos + 1;
                    if (head_pos == tail_pos) begin
                        head_pos = 0;
                        tail_pos = 0;
                    end
                end
                expected_results.push_back(r);
            end
            lqwl_pkg::CMD_COUNT: begin
                r.kind = lqwl_pkg::KIND_COUNT;
                r.occupancy = 7'(tail_pos - head_pos);
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            default: begin
                n = tail_pos - head_pos;
                if (n > int'(lqwl_pkg::MAX_RESULTS))
                    n = int'(lqwl_pkg::MAX_RESULTS);
                if (n > longest_list)
                    longest_list = n;
                for (int i = 0; i < n; i++) begin
                    pos = (it.cmd == lqwl_pkg::CMD_LIST_OLD) ? head_pos + i : tail_pos - 1 - i;
                    r = '0;
                    r.kind = lqwl_pkg::KIND_LISTED;
                    r.rec_id = id_mem[pos];
                    r.rec_tag = tag_mem[pos];
                    r.last = (i == n - 1);
                    expected_results.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors = n_errors + 1;
        end
    endtask

    // input transaction: predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            n_accepted = n_accepted + 1;
            predict_results(s_data);
        end
    end

    always @(negedge aclk) begin
        if (n_accepted != drv_seen) begin
            drv_seen = n_accepted;
            drv_busy = 1'b0;
            drv_wait = $urandom_range(0, drv_gap_max);
        end
        if (!drv_busy) begin
            if (drv_wait > 0) begin
                drv_wait = drv_wait - 1;
                s_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_data <= pending_cmds.pop_front();
                s_valid <= 1'b1;
                drv_busy = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results = n_results + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: 0x%0h", m_data);
                n_errors = n_errors + 1;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_data.kind));
                check_field("found", 64'(want.found), 64'(m_data.found));
                check_field("rec_id", 64'(want.rec_id), 64'(m_data.rec_id));
                check_field("rec_tag", want.rec_tag, m_data.rec_tag);
                check_field("occupancy", 64'(want.occupancy), 64'(m_data.occupancy));
                check_field("last", 64'(want.last), 64'(m_data.last));
            end
        end
    end

    always @(negedge aclk) begin
        if (n_results != rx_seen) begin
            rx_seen = n_results;
            rx_wait = $urandom_range(0, rx_gap_max);
        end
        if (rx_hold_req != rx_hold_done) begin
            rx_hold_done = rx_hold_req;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    task automatic push_cmd(input logic [2:0] c, input logic [30:0] id,
                            input logic [63:0] tag);
        lqwl_pkg::in_item_t it;
        it.cmd = c;
        it.student_id = id;
        it.name_tag = tag;
        pending_cmds.push_back(it);
        n_queued = n_queued + 1;
    endtask

    task automatic push_insert();
        push_cmd(lqwl_pkg::CMD_INSERT, 31'($urandom), {$urandom, $urandom});
    endtask

    // non-insert commands carry random id and tag so that ignored fields get exercised
    task automatic push_random(input int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            push_insert();
        else if (r < insert_pct + (100 - insert_pct) / 2)
            push_cmd(lqwl_pkg::CMD_REMOVE, 31'($urandom), {$urandom, $urandom});
        else if (r < insert_pct + 3 * (100 - insert_pct) / 4)
            push_cmd(3'($urandom_range(lqwl_pkg::CMD_LIST_OLD, CMD_SPARE_HI)), 31'($urandom),
                     {$urandom, $urandom});
        else
            push_cmd(lqwl_pkg::CMD_COUNT, 31'($urandom), {$urandom, $urandom});
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [6:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        capacity_reg = value;
    endtask

    initial begin
        int occ;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // empty queue, reset capacity
        push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        push_cmd(lqwl_pkg::CMD_COUNT, '0, '0);
        push_cmd(lqwl_pkg::CMD_LIST_OLD, '0, '0);
        push_cmd(lqwl_pkg::CMD_LIST_NEW, '0, '0);
        push_cmd(lqwl_pkg::CMD_INSERT, 31'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
        push_cmd(lqwl_pkg::CMD_INSERT, '0, '0);
        push_insert();
        push_cmd(lqwl_pkg::CMD_COUNT, 31'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
        push_cmd(lqwl_pkg::CMD_LIST_OLD, '0, '0);
        push_cmd(lqwl_pkg::CMD_LIST_NEW, '0, '0);
        push_cmd(CMD_SPARE_HI, 31'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
        push_cmd(CMD_SPARE_LO, '0, '0);
        push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        wait_idle();

        // small capacity: no reuse of space until the queue empties
        drv_gap_max = 16;
        rx_gap_max = 16;
        write_capacity(7'd2);
        repeat (3) push_insert();
        push_cmd(lqwl_pkg::CMD_LIST_OLD, '0, '0);
        push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        push_insert();
        push_cmd(lqwl_pkg::CMD_COUNT, '0, '0);
        push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        wait_idle();

        write_capacity(7'd0);
        push_insert();
        push_cmd(lqwl_pkg::CMD_COUNT, '0, '0);
        wait_idle();

        drv_gap_max = 16;
        rx_gap_max = 0;
        write_capacity(7'd64);
        repeat (6) push_random(55);
        wait_idle();

        // fill to the array end above the limit, then list with the receiver held off
        drv_gap_max = 0;
        rx_gap_max = 16;
        occ = tail_pos - head_pos;
        write_capacity(7'd127);
        repeat (occ) push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        repeat (QDEPTH + 2) push_insert();
        while (n_accepted != n_queued)
            @(posedge aclk);
        rx_hold_req = rx_hold_req + 1;
        push_cmd(lqwl_pkg::CMD_LIST_OLD, '0, '0);
        push_cmd(lqwl_pkg::CMD_LIST_NEW, '0, '0);
        push_cmd(lqwl_pkg::CMD_COUNT, '0, '0);
        push_cmd(lqwl_pkg::CMD_REMOVE, '0, '0);
        push_insert();
        wait_idle();

        // capacity below the tail: stored records stay, inserts drop
        drv_gap_max = 16;
        rx_gap_max = 16;
        write_capacity(7'($urandom_range(1, 10)));
        repeat (6) push_random(30);
        wait_idle();

        drv_gap_max = 0;
        rx_gap_max = 16;
        write_capacity(7'($urandom_range(1, 64)));
        repeat (6) push_random(50);
        wait_idle();

        $display("Summary: %0d commands in, %0d results out, %0d inserts dropped,",
                 n_accepted, n_results, n_dropped);
        $display("         capacities 0 to 127, longest listing %0d records", longest_list);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
